// File: design/maximal_munch_dfa_scanner_assert.svh
// ----------------------------------------------------------------------------
// Scanner assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MAXIMAL_MUNCH_DFA_SCANNER_ASSERT_SVH
`define MAXIMAL_MUNCH_DFA_SCANNER_ASSERT_SVH

// condition holds at every edge
`define MMDS_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("scanner invariant violated");

// same-cycle implication
`define MMDS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scanner implication violated");

// next-cycle implication
`define MMDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scanner sequence violated");

`endif

// File: design/mmds_pkg.sv
// ----------------------------------------------------------------------------
// mmds_pkg
// Types, constants and helpers shared by the longest-match scanner.
// ----------------------------------------------------------------------------
package mmds_pkg;

  localparam int STATE_COUNT   = 64;
  localparam int STATE_W       = 6;
  localparam int TABLE_COLUMNS = 129;
  localparam int TOKEN_COLUMN  = 128;
  localparam int TBL_DEPTH     = STATE_COUNT * TABLE_COLUMNS;
  localparam int TBL_AW        = $clog2(TBL_DEPTH);
  localparam int LEXEME_MAX    = 32;
  localparam int BUF_AW        = $clog2(LEXEME_MAX);
  localparam int CNT_W         = BUF_AW + 1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SCAN  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FEED,
    ST_RDBUF,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_CHECK,
    ST_RESOLVE,
    ST_FINISH
  } st_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  token_id;
    logic [31:0] start;
    logic [5:0]  length;
    logic [15:0] line;
    logic [7:0]  err_byte;
  } res_t;

  typedef struct packed {
    logic push;
    logic finish;
  } res_ctl_t;

  typedef struct packed {
    logic rdy;
    logic pend_valid;
  } res_st_t;

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [STATE_W-1:0] s,
                                                  input logic [7:0] col);
    tbl_addr = TBL_AW'(s) * TBL_AW'(TABLE_COLUMNS) + TBL_AW'(col);
  endfunction

  // {valid, code}
  function automatic logic [8:0] esc_code(input logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      8'h6E:   r = {1'b1, 8'd10};
      8'h61:   r = {1'b1, 8'd7};
      8'h74:   r = {1'b1, 8'd9};
      8'h72:   r = {1'b1, 8'd13};
      8'h62:   r = {1'b1, 8'd8};
      8'h66:   r = {1'b1, 8'd12};
      8'h76:   r = {1'b1, 8'd11};
      default: r = 9'd0;
    endcase
    esc_code = r;
  endfunction

endpackage

// File: design/mmds_tbl_mem.sv
// ----------------------------------------------------------------------------
// mmds_tbl_mem
// Transition table storage, one write and one registered read port.
// ----------------------------------------------------------------------------
module mmds_tbl_mem import mmds_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [TBL_AW-1:0] waddr_i,
  input  logic [8:0]        wdata_i,
  input  logic              re_i,
  input  logic [TBL_AW-1:0] raddr_i,
  output logic [8:0]        rdata_o
);

  logic [8:0] mem [TBL_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: design/mmds_lex_buf.sv
// ----------------------------------------------------------------------------
// mmds_lex_buf
// Circular lexeme buffer, one write and one registered read port.
// ----------------------------------------------------------------------------
module mmds_lex_buf import mmds_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [BUF_AW-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [BUF_AW-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [LEXEME_MAX];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: design/mmds_result.sv
// ----------------------------------------------------------------------------
// mmds_result
// Holds the newest result until the next one (or the end of the request)
// decides its last flag, then drives the output register.
// ----------------------------------------------------------------------------
module mmds_result import mmds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  res_ctl_t    ctl_i,
  input  res_t        res_i,
  output res_st_t     st_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_o,
  output logic        last_o
);

  logic pend_valid_q, pend_valid_d;
  logic out_valid_q, out_valid_d;
  logic load;
  res_t pend_q;

  assign st_o.rdy        = !pend_valid_q || !out_valid_q || out_ready_i;
  assign st_o.pend_valid = pend_valid_q;
  assign load            = pend_valid_q && st_o.rdy && (ctl_i.push || ctl_i.finish);

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (ctl_i.push && st_o.rdy) begin
      pend_valid_d = 1'b1;
    end else if (ctl_i.finish && st_o.rdy) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push && st_o.rdy) begin
      pend_q <= res_i;
    end
    if (load) begin
      out_o  <= pend_q;
      last_o <= ctl_i.finish;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/maximal_munch_dfa_scanner.sv
// ----------------------------------------------------------------------------
// maximal_munch_dfa_scanner
// Table-driven longest-match scanner with escape decoding and line counting.
// ----------------------------------------------------------------------------
// After reset the transition table is swept to "no path", one entry per cycle,
// with in_ready_o low. A scanned byte, other than a backslash that opens an
// escape, keeps the block busy from its accepting cycle to the next ready cycle
// (accept, feed, next-state read, token read, token check, buffer check,
// finish). Every buffered byte replayed after a result passes through a buffer
// read, the two lookups and a check. A result from a dead path takes the place
// of the token lookup. A result from a full buffer or from end of input adds a
// resolve and a check step. A stalled output holds the resolve or finish step.
// The table memory has a single read port, which the two lookups share in turn.
// Results of one request leave through an output register and the final one
// carries last_o.
module maximal_munch_dfa_scanner import mmds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [5:0]        table_state_i,
  input  logic [7:0]        table_column_i,
  input  logic signed [8:0] table_value_i,
  input  logic [7:0]        char_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              kind_o,
  output logic [7:0]        token_id_o,
  output logic [31:0]       lexeme_start_o,
  output logic [5:0]        lexeme_length_o,
  output logic [15:0]       line_number_o,
  output logic [7:0]        error_byte_o,
  output logic              last_o
);

  st_e state_q, state_d;

  logic [TBL_AW-1:0]  clr_q;
  logic [STATE_W-1:0] dfa_q;
  logic [CNT_W-1:0]   pos_q, cnt_q, acc_len_q;
  logic [BUF_AW-1:0]  head_q;
  logic [7:0]         acc_tok_q;
  logic               acc_valid_q;
  logic [31:0]        offset_q;
  logic [15:0]        line_q;
  logic               pend_bs_q, second_q, flush_q, from_buf_q;
  logic [7:0]         feed_q, feed2_q, first_q;

  logic               in_fire;
  logic               tbl_we, tbl_re;
  logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
  logic [8:0]         tbl_wdata, tbl_rd;
  logic               buf_we, buf_re;
  logic [7:0]         buf_rd;
  logic [7:0]         char_w;
  logic               nx_dead, tok_ok;
  logic [CNT_W-1:0]   drop;
  logic [8:0]         esc;
  res_ctl_t           res_ctl;
  res_st_t            res_st;
  res_t               res_new, res_out;

  assign in_fire = in_valid_i && in_ready_o;
  assign char_w  = from_buf_q ? buf_rd : feed_q;
  assign nx_dead = tbl_rd[8] || (tbl_rd[7:STATE_W] != '0);
  assign tok_ok  = !tbl_rd[8] && (tbl_rd[7:0] != 8'd0);
  assign drop    = acc_valid_q ? acc_len_q : CNT_W'(1);
  assign esc     = esc_code(char_byte_i);

  assign res_new.kind     = !acc_valid_q;
  assign res_new.token_id = acc_valid_q ? acc_tok_q : 8'd0;
  assign res_new.start    = offset_q;
  assign res_new.length   = 6'(drop);
  assign res_new.line     = line_q;
  assign res_new.err_byte = acc_valid_q ? 8'd0 : first_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (clr_q == TBL_AW'(TBL_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire && op_i == OP_SCAN) begin
          if (pend_bs_q || char_byte_i != CH_BSLASH) state_d = ST_FEED;
        end else if (in_fire && op_i == OP_END) begin
          state_d = pend_bs_q ? ST_FEED : ST_CHECK;
        end
      end
      ST_FEED:    state_d = ST_T1;
      ST_RDBUF:   state_d = ST_T1;
      ST_T1:      state_d = char_w[7] ? ST_RESOLVE : ST_T2;
      ST_T2:      state_d = nx_dead ? ST_RESOLVE : ST_T3;
      ST_T3:      state_d = ST_CHECK;
      ST_CHECK: begin
        priority if (pos_q < cnt_q)                   state_d = ST_RDBUF;
        else if (cnt_q == CNT_W'(LEXEME_MAX))         state_d = ST_RESOLVE;
        else if (second_q)                            state_d = ST_FEED;
        else if (flush_q && cnt_q != '0)              state_d = ST_RESOLVE;
        else                                          state_d = ST_FINISH;
      end
      ST_RESOLVE: if (res_st.rdy) state_d = ST_CHECK;
      ST_FINISH:  if (res_st.rdy) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // outputs and strobes
  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    tbl_we         = 1'b0;
    tbl_waddr      = clr_q;
    tbl_wdata      = '1;
    tbl_re         = 1'b0;
    tbl_raddr      = tbl_addr(dfa_q, char_w);
    buf_we         = (state_q == ST_FEED);
    buf_re         = (state_q == ST_RDBUF);
    res_ctl.push   = (state_q == ST_RESOLVE);
    res_ctl.finish = (state_q == ST_FINISH);
    unique case (state_q)
      ST_CLEAR: tbl_we = 1'b1;
      ST_IDLE: begin
        tbl_waddr = tbl_addr(table_state_i, table_column_i);
        tbl_wdata = table_value_i;
        tbl_we    = in_fire && op_i == OP_WRITE &&
                    (!table_column_i[7] || table_column_i == 8'(TOKEN_COLUMN));
      end
      // bytes without a column never touch the table
      ST_T1: tbl_re = !char_w[7];
      ST_T2: begin
        tbl_re    = !nx_dead;
        tbl_raddr = tbl_addr(tbl_rd[STATE_W-1:0], 8'(TOKEN_COLUMN));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      dfa_q       <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      acc_len_q   <= '0;
      acc_valid_q <= 1'b0;
      head_q      <= '0;
      offset_q    <= '0;
      line_q      <= '0;
      pend_bs_q   <= 1'b0;
      second_q    <= 1'b0;
      flush_q     <= 1'b0;
      from_buf_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_CLEAR: clr_q <= clr_q + TBL_AW'(1);
        ST_IDLE: begin
          if (in_fire && op_i == OP_SCAN) begin
            if (pend_bs_q) begin
              pend_bs_q <= !esc[8] && char_byte_i == CH_BSLASH;
              second_q  <= !esc[8] && char_byte_i != CH_BSLASH;
            end else begin
              pend_bs_q <= char_byte_i == CH_BSLASH;
            end
          end else if (in_fire && op_i == OP_END) begin
            pend_bs_q <= 1'b0;
            flush_q   <= 1'b1;
          end
        end
        ST_FEED: begin
          from_buf_q <= 1'b0;
          cnt_q      <= cnt_q + CNT_W'(1);
          if (feed_q == CH_NEWLINE && line_q != 16'hFFFF) line_q <= line_q + 16'd1;
        end
        ST_RDBUF: from_buf_q <= 1'b1;
        ST_T2: begin
          if (!nx_dead) begin
            dfa_q <= tbl_rd[STATE_W-1:0];
            pos_q <= pos_q + CNT_W'(1);
          end
        end
        ST_T3: begin
          if (tok_ok) begin
            acc_valid_q <= 1'b1;
            acc_len_q   <= pos_q;
          end
        end
        ST_CHECK: begin
          if (pos_q >= cnt_q && cnt_q != CNT_W'(LEXEME_MAX)) begin
            if (second_q) begin
              second_q <= 1'b0;
            end else if (flush_q && cnt_q == '0) begin
              flush_q     <= 1'b0;
              dfa_q       <= '0;
              acc_valid_q <= 1'b0;
              acc_len_q   <= '0;
            end
          end
        end
        ST_RESOLVE: begin
          if (res_st.rdy) begin
            head_q      <= head_q + drop[BUF_AW-1:0];
            cnt_q       <= cnt_q - drop;
            offset_q    <= offset_q + 32'(drop);
            pos_q       <= '0;
            dfa_q       <= '0;
            acc_valid_q <= 1'b0;
            acc_len_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_fire) begin
      if (op_i == OP_SCAN) begin
        if (pend_bs_q && esc[8]) begin
          feed_q <= esc[7:0];
        end else if (pend_bs_q) begin
          feed_q  <= CH_BSLASH;
          feed2_q <= char_byte_i;
        end else begin
          feed_q <= char_byte_i;
        end
      end else begin
        feed_q <= CH_BSLASH;
      end
    end
    if (state_q == ST_CHECK && second_q) begin
      feed_q <= feed2_q;
    end
    if (state_q == ST_T1 && pos_q == '0) begin
      first_q <= char_w;
    end
    if (state_q == ST_T3 && tok_ok) begin
      acc_tok_q <= tbl_rd[7:0];
    end
  end

  mmds_tbl_mem u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rd)
  );

  mmds_lex_buf u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (head_q + cnt_q[BUF_AW-1:0]),
    .wdata_i (feed_q),
    .re_i    (buf_re),
    .raddr_i (head_q + pos_q[BUF_AW-1:0]),
    .rdata_o (buf_rd)
  );

  mmds_result u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (res_ctl),
    .res_i       (res_new),
    .st_o        (res_st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res_out),
    .last_o      (last_o)
  );

  assign kind_o          = res_out.kind;
  assign token_id_o      = res_out.token_id;
  assign lexeme_start_o  = res_out.start;
  assign lexeme_length_o = res_out.length;
  assign line_number_o   = res_out.line;
  assign error_byte_o    = res_out.err_byte;

`include "maximal_munch_dfa_scanner_assert.svh"

  `MMDS_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(LEXEME_MAX))
  `MMDS_ASSERT_ALWAYS(a_pos_in_buf, pos_q <= cnt_q)
  `MMDS_ASSERT_IMPLY(a_idle_clean, state_q == ST_IDLE, !res_st.pend_valid && !second_q)
  `MMDS_ASSERT_NEXT(a_push_holds, res_ctl.push && res_st.rdy, res_st.pend_valid)

endmodule
